@@ hdl/sipq_pkg.sv @@
// Package for the sorted-insert max priority queue.
// Holds default sizes, status codes and the cell control struct.
// No dependencies.
package sipq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int KEY_BITS_DEF = 16;
    localparam int TAG_BITS_DEF = 16;

    // occupancy port width, count taken modulo 32
    localparam int OCC_W = 5;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic ins;
        logic pop;
    } cell_ctrl_t;

endpackage

@@ hdl/sipq_cell.sv @@
// One slot of the sorted row: holds a key and a tag.
// Shifts towards the tail on insert, towards the head on pop.
// Depends on sipq_pkg.
module sipq_cell
    import sipq_pkg::*;
#(
    parameter int IDX      = 0,
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF,
    parameter int TAG_BITS = TAG_BITS_DEF,
    localparam int CNT_W   = $clog2(CAPACITY + 1)
)
(
    input  logic                clk,
    input  cell_ctrl_t          ctrl,
    input  logic [CNT_W-1:0]    count,
    input  logic [KEY_BITS-1:0] new_key,
    input  logic [TAG_BITS-1:0] new_tag,
    input  logic [KEY_BITS-1:0] left_key,
    input  logic [TAG_BITS-1:0] left_tag,
    input  logic                left_greater,
    input  logic [KEY_BITS-1:0] right_key,
    input  logic [TAG_BITS-1:0] right_tag,
    output logic [KEY_BITS-1:0] key,
    output logic [TAG_BITS-1:0] tag,
    output logic                greater
);

    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;
    logic                occupied;

    assign occupied = CNT_W'(IDX) < count;
    // new entry goes ahead of this slot: empty, or held key strictly smaller
    assign greater  = !occupied || (new_key > key_reg);

    always_comb
    begin
        key_next = key_reg;
        tag_next = tag_reg;
        if (ctrl.pop)
        begin
            key_next = right_key;
            tag_next = right_tag;
        end
        else if (ctrl.ins)
        begin
            if (left_greater)
            begin
                key_next = left_key;
                tag_next = left_tag;
            end
            else if (greater)
            begin
                key_next = new_key;
                tag_next = new_tag;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

    assign key = key_reg;
    assign tag = tag_reg;

endmodule

@@ hdl/sorted_insert_max_priority_queue_unit.sv @@
// Sorted-insert max priority queue, top level: a row of compare-and-shift cells.
// The result is registered from the accepted input transaction.
// Throughput: one insert or pop per cycle while the input is not stalled; every cell compares in parallel.
// Input stalls only while a result is held and the output is stalled.
// Reset clears the entry count and output valid; slot contents are not cleared.
module sorted_insert_max_priority_queue_unit
    import sipq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF,
    parameter int TAG_BITS = TAG_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                mode,
    input  logic [KEY_BITS-1:0] key,
    input  logic [TAG_BITS-1:0] tag,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          status,
    output logic [KEY_BITS-1:0] out_key,
    output logic [TAG_BITS-1:0] out_tag,
    output logic [OCC_W-1:0]    occupancy
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]    count_reg, count_next;
    logic                out_valid_reg, out_valid_next;
    status_t             status_reg, status_next;
    logic [KEY_BITS-1:0] out_key_reg, out_key_next;
    logic [TAG_BITS-1:0] out_tag_reg, out_tag_next;
    logic [OCC_W-1:0]    occ_reg, occ_next;

    logic       accept, is_full, is_empty;
    cell_ctrl_t ctrl;

    logic [KEY_BITS-1:0] cell_key [CAPACITY];
    logic [TAG_BITS-1:0] cell_tag [CAPACITY];
    logic                cell_gt  [CAPACITY];

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign is_full  = count_reg == CNT_W'(CAPACITY);
    assign is_empty = count_reg == '0;

    assign ctrl.ins = accept && !mode && !is_full;
    assign ctrl.pop = accept && mode && !is_empty;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [KEY_BITS-1:0] lk, rk;
        logic [TAG_BITS-1:0] lt, rt;
        logic                lg;

        if (i == 0)
        begin : g_head
            assign lk = key;
            assign lt = tag;
            assign lg = 1'b0;
        end
        else
        begin : g_body
            assign lk = cell_key[i-1];
            assign lt = cell_tag[i-1];
            assign lg = cell_gt[i-1];
        end

        // tail slot takes its own content on pop; it falls outside the count anyway
        if (i == CAPACITY - 1)
        begin : g_tail
            assign rk = cell_key[i];
            assign rt = cell_tag[i];
        end
        else
        begin : g_next
            assign rk = cell_key[i+1];
            assign rt = cell_tag[i+1];
        end

        sipq_cell #(
            .IDX      (i),
            .CAPACITY (CAPACITY),
            .KEY_BITS (KEY_BITS),
            .TAG_BITS (TAG_BITS)
        ) u_cell (
            .clk          (clk),
            .ctrl         (ctrl),
            .count        (count_reg),
            .new_key      (key),
            .new_tag      (tag),
            .left_key     (lk),
            .left_tag     (lt),
            .left_greater (lg),
            .right_key    (rk),
            .right_tag    (rt),
            .key          (cell_key[i]),
            .tag          (cell_tag[i]),
            .greater      (cell_gt[i])
        );
    end

    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        out_key_next   = out_key_reg;
        out_tag_next   = out_tag_reg;
        occ_next       = occ_reg;
        if (ctrl.ins)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctrl.pop)
        begin
            count_next = count_reg - 1'b1;
        end
        if (accept)
        begin
            out_valid_next = 1'b1;
            out_key_next   = '0;
            out_tag_next   = '0;
            occ_next       = OCC_W'(count_next);
            if (mode)
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    status_next  = ST_OK;
                    out_key_next = cell_key[0];
                    out_tag_next = cell_tag[0];
                end
            end
            else
            begin
                status_next = is_full ? ST_FULL : ST_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        out_key_reg <= out_key_next;
        out_tag_reg <= out_tag_next;
        occ_reg     <= occ_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign out_key   = out_key_reg;
    assign out_tag   = out_tag_reg;
    assign occupancy = occ_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode && !is_empty) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("pop did not remove one entry");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CNT_W'(2)) |-> (cell_key[0] >= cell_key[1]))
        else $error("head slots out of order");

    a_full_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !mode && is_full) |=> (count_reg == $past(count_reg)))
        else $error("insert into full queue changed the count");

endmodule

@@ bench/sorted_insert_max_priority_queue_unit_tb.sv @@
// Testbench for the sorted-insert max priority queue: directed rows, then random
// inserts and pops, each result checked against a fixed expectation or a behavioural sorted list.
// Depends on sipq_pkg and sorted_insert_max_priority_queue_unit.
module sorted_insert_max_priority_queue_unit_tb;
    import sipq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = CAPACITY_DEF;
    localparam int KW = KEY_BITS_DEF;
    localparam int TW = TAG_BITS_DEF;
    localparam int RANDOM_ITEMS = 850;
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD_CYCLES = 60;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_POP = 1'b1;

    typedef struct packed {
        status_t         status;
        logic [KW-1:0]   key;
        logic [TW-1:0]   tag;
        logic [OCC_W-1:0] occ;
    } pq_result_t;

    typedef struct packed {
        logic          mode;
        logic [KW-1:0] key;
        logic [TW-1:0] tag;
        logic          fixed;
        pq_result_t    res;
    } dir_row_t;

    localparam int DIR_ROWS = 22;

    // rows with fixed set carry their own expected result; the rest use the predictor
    dir_row_t directed_rows [0:DIR_ROWS-1] = '{
        '{MODE_POP,    16'hDEAD, 16'hBEEF, 1'b1, '{ST_EMPTY, 16'h0, 16'h0, 5'd0}},
        '{MODE_INSERT, 16'h0000, 16'h0000, 1'b1, '{ST_OK, 16'h0, 16'h0, 5'd1}},
        '{MODE_INSERT, 16'hFFFF, 16'hFFFF, 1'b1, '{ST_OK, 16'h0, 16'h0, 5'd2}},
        '{MODE_INSERT, 16'h8000, 16'h1234, 1'b1, '{ST_OK, 16'h0, 16'h0, 5'd3}},
        '{MODE_INSERT, 16'h8000, 16'h0001, 1'b1, '{ST_OK, 16'h0, 16'h0, 5'd4}},
        '{MODE_INSERT, 16'h7FFF, 16'hA5A5, 1'b0, '0},
        '{MODE_INSERT, 16'h5555, 16'h5A5A, 1'b0, '0},
        '{MODE_INSERT, 16'h2AAA, 16'h00F0, 1'b0, '0},
        '{MODE_INSERT, 16'h0001, 16'hF00F, 1'b0, '0},
        '{MODE_INSERT, 16'h7FFF, 16'h0F0F, 1'b0, '0},
        '{MODE_INSERT, 16'h1234, 16'h8001, 1'b0, '0},
        '{MODE_INSERT, 16'h4000, 16'h7FFE, 1'b0, '0},
        '{MODE_INSERT, 16'h00FF, 16'h3333, 1'b0, '0},
        '{MODE_INSERT, 16'h3C3C, 16'hCCCC, 1'b0, '0},
        '{MODE_INSERT, 16'h0F0F, 16'h6969, 1'b0, '0},
        '{MODE_INSERT, 16'h6666, 16'h9696, 1'b0, '0},
        '{MODE_INSERT, 16'h0002, 16'h0002, 1'b0, '0},
        // full: a top key must be dropped
        '{MODE_INSERT, 16'hFFFF, 16'h0BAD, 1'b1, '{ST_FULL, 16'h0, 16'h0, 5'd16}},
        '{MODE_POP,    16'h1111, 16'h2222, 1'b1, '{ST_OK, 16'hFFFF, 16'hFFFF, 5'd15}},
        // equal keys leave in arrival order
        '{MODE_POP,    16'h0000, 16'hFFFF, 1'b1, '{ST_OK, 16'h8000, 16'h1234, 5'd14}},
        '{MODE_POP,    16'hFFFF, 16'h0000, 1'b1, '{ST_OK, 16'h8000, 16'h0001, 5'd13}},
        '{MODE_POP,    16'h0000, 16'h0000, 1'b0, '0}
    };

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic             mode = 1'b0;
    logic [KW-1:0]    key = '0;
    logic [TW-1:0]    tag = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [1:0]       status;
    logic [KW-1:0]    out_key;
    logic [TW-1:0]    out_tag;
    logic [OCC_W-1:0] occupancy;

    sorted_insert_max_priority_queue_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .key       (key),
        .tag       (tag),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .out_key   (out_key),
        .out_tag   (out_tag),
        .occupancy (occupancy)
    );

    always #10 clk = ~clk;

    // behavioural copy of the queue contents
    logic [KW-1:0] held_keys [0:CAP-1];
    logic [TW-1:0] held_tags [0:CAP-1];
    int            held_count = 0;

    pq_result_t pending_results [$];
    int         fail_count = 0;

    // current transaction's fixed expectation, set alongside the payload
    logic       cur_fixed = 1'b0;
    pq_result_t cur_fixed_res = '0;

    int send_idle_pct = 22;
    int recv_idle_pct = 66;
    int item_idx = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    function automatic pq_result_t queue_step(input logic m, input logic [KW-1:0] k,
                                              input logic [TW-1:0] t);
        pq_result_t r;
        int i;
        r = '0;
        if (m == MODE_POP) begin
            if (held_count == 0) begin
                r.status = ST_EMPTY;
            end
            else begin
                r.status = ST_OK;
                r.key = held_keys[0];
                r.tag = held_tags[0];
                for (i = 1; i < held_count; i++)
                begin
                    held_keys[i-1] = held_keys[i];
                    held_tags[i-1] = held_tags[i];
                end
                held_count--;
            end
        end
        else if (held_count >= CAP) begin
            r.status = ST_FULL;
        end
        else begin
            r.status = ST_OK;
            i = held_count;
            while (i > 0 && k > held_keys[i-1])
            begin
                held_keys[i] = held_keys[i-1];
                held_tags[i] = held_tags[i-1];
                i--;
            end
            held_keys[i] = k;
            held_tags[i] = t;
            held_count++;
        end
        r.occ = held_count[OCC_W-1:0];
        return r;
    endfunction

    // monitor: inputs first, so a same-edge result would still find its expectation
    always @(posedge clk)
    begin
        pq_result_t predicted;
        pq_result_t want;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                predicted = queue_step(mode, key, tag);
                pending_results.push_back(cur_fixed ? cur_fixed_res : predicted);
            end
            if (out_valid && !out_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result with nothing pending: status %0d key %h tag %h occ %0d",
                           status, out_key, out_tag, occupancy);
                    fail_count++;
                end
                else begin
                    want = pending_results.pop_front();
                    if (status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        fail_count++;
                    end
                    if (out_key !== want.key) begin
                        $error("out_key: expected %h, got %h", want.key, out_key);
                        fail_count++;
                    end
                    if (out_tag !== want.tag) begin
                        $error("out_tag: expected %h, got %h", want.tag, out_tag);
                        fail_count++;
                    end
                    if (occupancy !== want.occ) begin
                        $error("occupancy: expected %0d, got %0d", want.occ, occupancy);
                        fail_count++;
                    end
                end
            end
        end
    end

    // receiver stall, with one long hold-off to back the block up
    always @(negedge clk)
    begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (!hold_done && item_idx >= 300) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // watchdog on cycles with no transaction on either side
    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic offer(input logic m, input logic [KW-1:0] k, input logic [TW-1:0] t,
                         input logic fixed, input pq_result_t res);
        while (hold_left == 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        cur_fixed = fixed;
        cur_fixed_res = res;
        mode <= m;
        key <= k;
        tag <= t;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    function automatic logic [KW-1:0] pick_key();
        case ($urandom_range(3))
            0: pick_key = KW'($urandom_range(3));
            1: pick_key = $urandom_range(1) ? '1 : '0;
            default: pick_key = KW'($urandom);
        endcase
    endfunction

    initial begin
        bit filling;
        logic m;
        filling = 1'b1;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            offer(directed_rows[r].mode, directed_rows[r].key, directed_rows[r].tag,
                  directed_rows[r].fixed, directed_rows[r].res);
        end

        // random part: swing between filling and draining so full and empty both recur
        for (item_idx = 0; item_idx < RANDOM_ITEMS; item_idx++)
        begin
            if (item_idx == RANDOM_ITEMS / 3) begin
                send_idle_pct = 66;
                recv_idle_pct = 22;
            end
            else if (item_idx == 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (held_count >= CAP && $urandom_range(3) == 0)
                filling = 1'b0;
            else if (held_count == 0 && $urandom_range(3) == 0)
                filling = 1'b1;
            if (filling)
                m = ($urandom_range(99) < 25) ? MODE_POP : MODE_INSERT;
            else
                m = ($urandom_range(99) < 25) ? MODE_INSERT : MODE_POP;
            offer(m, pick_key(), TW'($urandom), 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
